@@ hdl/assert_macros.svh @@
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LRUC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lruc assertion failed");

// next-cycle implication
`define LRUC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lruc assertion failed");

`endif

@@ hdl/lruc_pkg.sv @@
package lruc_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
	localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_SET = 1'b1
	} lruc_cmd_t;

	// rank table update request, issued at most once, at the end of an item
	typedef struct packed {
		logic touch;  // make the hit entry most recent
		logic evict;  // drop the oldest entry
		logic age;    // every remaining valid entry gets one older
		logic place;  // new entry goes into the chosen slot
	} lruc_upd_t;

endpackage

@@ hdl/lruc_ifs.sv @@
interface lruc_req_if import lruc_pkg::*;;
	logic                    valid;
	logic                    ready;
	lruc_cmd_t               cmd;
	logic signed [KEY_W-1:0] key;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output cmd, output key, output value, input ready);
	modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface lruc_rsp_if import lruc_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic                    hit;
	logic signed [VAL_W-1:0] read_value;

	modport source (output valid, output hit, output read_value, input ready);
	modport sink   (input valid, input hit, input read_value, output ready);
endinterface

@@ hdl/lruc_rank.sv @@
// Valid bits and recency ranks, one lane per entry. Rank 0 is the newest.
module lruc_rank import lruc_pkg::*; #(
	parameter int ENTRIES = 16,
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [IW-1:0] rd_idx,
	output logic          rd_valid,
	output logic [IW-1:0] rd_rank,
	input  lruc_upd_t     upd,
	input  logic [IW-1:0] touch_idx,
	input  logic [IW-1:0] touch_rank,
	input  logic [IW-1:0] evict_idx,
	input  logic [IW-1:0] slot_idx
);

	logic [ENTRIES-1:0] valid_q;
	logic [IW-1:0]      rank_q [ENTRIES];
	logic [ENTRIES-1:0] evict_hit;
	logic [ENTRIES-1:0] slot_hit;
	logic [ENTRIES-1:0] touch_hit;

	assign rd_valid = valid_q[rd_idx];
	assign rd_rank  = rank_q[rd_idx];

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			evict_hit[i] = upd.evict && (IW'(i) == evict_idx);
			slot_hit[i]  = upd.place && (IW'(i) == slot_idx);
			touch_hit[i] = IW'(i) == touch_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (upd.touch) begin
					if (touch_hit[i]) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && rank_q[i] < touch_rank) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end else if (slot_hit[i]) begin
					valid_q[i] <= 1'b1;
					rank_q[i]  <= '0;
				end else if (evict_hit[i]) begin
					valid_q[i] <= 1'b0;
					rank_q[i]  <= '0;
				end else if (upd.age && valid_q[i]) begin
					rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
		end
	end

endmodule

@@ hdl/lru_key_value_cache.sv @@
// Channel  Dir  Handshake    Payload
// req      in   valid/ready  cmd, key, value
// rsp      out  valid/ready  hit, read_value (one per get, none per set)
// cfg      in   cfg_we       cfg_wdata = capacity
//
// A looked-up item scans the key/value memory, one key compare per cycle, then
// ends with an update in the finish state. A get with a non-positive key, or
// any get at capacity zero, skips the scan and is answered with a miss; a set
// at capacity zero is dropped. The response register frees the request side;
// a get only stalls in the finish state while an older response is not taken.
// Reset empties the cache at once and sets capacity to 16.
module lru_key_value_cache import lruc_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	lruc_req_if.sink         req,
	lruc_rsp_if.source       rsp
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OW = $clog2(ENTRIES + 1);
	localparam int CW = ((OW > CAP_W) ? OW : CAP_W) + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t           state_q;
	lruc_cmd_t        cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	logic [CAP_W-1:0] cap_q;
	logic [OW-1:0]    occ_q;
	logic [OW-1:0]    scan_idx_q;
	logic             rd_v_s1;
	logic [IW-1:0]    rd_idx_s1;
	logic [KEY_W-1:0] key_rd_s1;
	logic [VAL_W-1:0] val_rd_s1;

	logic             hit_found_q;
	logic [IW-1:0]    hit_idx_q;
	logic [IW-1:0]    hit_rank_q;
	logic [VAL_W-1:0] hit_val_q;
	logic             free_found_q;
	logic [IW-1:0]    free_idx_q;
	logic             old_found_q;
	logic [IW-1:0]    old_idx_q;
	logic [IW-1:0]    old_rank_q;

	logic             out_valid_q;
	logic             out_hit_q;
	logic [VAL_W-1:0] out_val_q;

	logic [KEY_W-1:0] key_mem [ENTRIES];
	logic [VAL_W-1:0] val_mem [ENTRIES];

	logic             accept;
	logic             key_pos;
	logic             cap_zero;
	logic [CW-1:0]    eff_cap;
	logic             need_evict;
	logic             evict_do;
	logic [IW-1:0]    slot_idx;
	logic             finish_go;
	lruc_upd_t        upd;
	logic             ent_valid;
	logic [IW-1:0]    ent_rank;
	logic [IW-1:0]    scan_addr;
	logic [IW-1:0]    wr_addr;
	logic             wr_key;
	logic             wr_val;

	assign req.ready      = state_q == ST_IDLE;
	assign accept         = req.valid && req.ready;
	assign rsp.valid      = out_valid_q;
	assign rsp.hit        = out_hit_q;
	assign rsp.read_value = out_val_q;

	assign key_pos   = !req.key[KEY_W-1] && (req.key != '0);
	assign cap_zero  = cap_q == '0;
	assign scan_addr = scan_idx_q[IW-1:0];

	always_comb begin
		eff_cap = (CW'(cap_q) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(cap_q);
		need_evict = (CW'(occ_q) + CW'(1)) > eff_cap;
		evict_do = need_evict && old_found_q;
		// first free slot after the eviction
		slot_idx = (free_found_q && !(evict_do && old_idx_q < free_idx_q)) ?
			free_idx_q : old_idx_q;
		finish_go = (state_q == ST_FINISH) &&
			(cmd_q == CMD_SET || !out_valid_q || rsp.ready);
		upd.touch = finish_go && hit_found_q;
		upd.age   = finish_go && cmd_q == CMD_SET && !hit_found_q;
		upd.evict = upd.age && evict_do;
		upd.place = upd.age && (free_found_q || evict_do);
		wr_addr   = hit_found_q ? hit_idx_q : slot_idx;
		wr_key    = upd.place;
		wr_val    = upd.place || (finish_go && cmd_q == CMD_SET && hit_found_q);
	end

	lruc_rank #(
		.ENTRIES (ENTRIES)
	) u_rank (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_idx     (rd_idx_s1),
		.rd_valid   (ent_valid),
		.rd_rank    (ent_rank),
		.upd        (upd),
		.touch_idx  (hit_idx_q),
		.touch_rank (hit_rank_q),
		.evict_idx  (old_idx_q),
		.slot_idx   (slot_idx)
	);

	always_ff @(posedge clk) begin
		if (wr_key) begin
			key_mem[wr_addr] <= key_q;
		end
		if (wr_val) begin
			val_mem[wr_addr] <= value_q;
		end
		key_rd_s1 <= key_mem[scan_addr];
		val_rd_s1 <= val_mem[scan_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cmd_q        <= CMD_GET;
			key_q        <= '0;
			value_q      <= '0;
			cap_q        <= CAP_RESET;
			occ_q        <= '0;
			scan_idx_q   <= '0;
			rd_v_s1      <= 1'b0;
			rd_idx_s1    <= '0;
			hit_found_q  <= 1'b0;
			hit_idx_q    <= '0;
			hit_rank_q   <= '0;
			hit_val_q    <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			old_found_q  <= 1'b0;
			old_idx_q    <= '0;
			old_rank_q   <= '0;
			out_valid_q  <= 1'b0;
			out_hit_q    <= 1'b0;
			out_val_q    <= '0;
		end else begin
			rd_v_s1 <= (state_q == ST_SCAN) && (scan_idx_q != OW'(ENTRIES));
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			// load a new get result, else hold until taken
			out_valid_q <= (finish_go && cmd_q == CMD_GET) || (out_valid_q && !rsp.ready);

			// compare stage: one stored entry per cycle
			if (rd_v_s1) begin
				if (ent_valid) begin
					if (!hit_found_q && key_rd_s1 == key_q) begin
						hit_found_q <= 1'b1;
						hit_idx_q   <= rd_idx_s1;
						hit_rank_q  <= ent_rank;
						hit_val_q   <= val_rd_s1;
					end
					if (!old_found_q || ent_rank > old_rank_q) begin
						old_found_q <= 1'b1;
						old_idx_q   <= rd_idx_s1;
						old_rank_q  <= ent_rank;
					end
				end else if (!free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= rd_idx_s1;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q        <= req.cmd;
						key_q        <= req.key;
						value_q      <= req.value;
						scan_idx_q   <= '0;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						old_found_q  <= 1'b0;
						if (cap_zero || (req.cmd == CMD_GET && !key_pos)) begin
							// disabled cache or invalid key: answer a get with a miss
							state_q <= (req.cmd == CMD_SET) ? ST_IDLE : ST_FINISH;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rd_idx_s1 <= scan_addr;
					if (scan_idx_q != OW'(ENTRIES)) begin
						scan_idx_q <= scan_idx_q + 1'b1;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (finish_go) begin
						state_q <= ST_IDLE;
						occ_q   <= OW'(occ_q + OW'(upd.place) - OW'(upd.evict));
						if (cmd_q == CMD_GET) begin
							out_hit_q   <= hit_found_q;
							out_val_q   <= hit_found_q ? hit_val_q : MISS_VALUE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hdl/lruc_checker.sv @@
`include "assert_macros.svh"

module lruc_sva import lruc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             req_cmd,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic             rsp_hit,
	input logic [VAL_W-1:0] rsp_read_value
);

	// a get always keeps the block busy for at least the following cycle
	`LRUC_ASSERT_NXT(a_get_busy, clk, arst_n, req_valid && req_ready && req_cmd == CMD_GET, !req_ready)

	`LRUC_ASSERT_IMP(a_miss_value, clk, arst_n, rsp_valid && !rsp_hit, rsp_read_value == MISS_VALUE)

	// a response is only produced from the update cycle, never from idle
	`LRUC_ASSERT_IMP(a_rsp_from_busy, clk, arst_n, $rose(rsp_valid), $past(!req_ready))

	`LRUC_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value))

endmodule

bind lru_key_value_cache lruc_sva u_lruc_sva (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_cmd        (req.cmd),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_hit        (rsp.hit),
	.rsp_read_value (rsp.read_value)
);
